// File: rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg: shared types and codes of the flow hash classifier
// Operation, status and register codes, sequencer states, entry layout.
// ----------------------------------------------------------------------------
package fhc_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DST_MASK    = 2'd0;
    localparam logic [1:0] CFG_DST_SHIFT   = 2'd1;
    localparam logic [1:0] CFG_USE_FLOW_ID = 2'd2;

    localparam int ADDR_W = 32;
    localparam int FLOW_W = 32;
    localparam int SLOT_W = 16;

    // one stored table entry
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [FLOW_W-1:0] flow;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep bucket fill counts to zero
        ST_IDLE,    // wait for an input word
        ST_MOD,     // bucket = hash mod bucket count, three multiply steps
        ST_FILL,    // read bucket fill count
        ST_FILLW,   // fill count back; insert writes here
        ST_PROBE,   // read one way of the bucket
        ST_CMP,     // compare that way against the key
        ST_DONE     // hand result to the output register
    } t_state;

endpackage

// File: rtl/fhc_ram.sv
// ----------------------------------------------------------------------------
// fhc_ram: generic single write port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/flow_hash_classifier_unit.sv
// ----------------------------------------------------------------------------
// flow_hash_classifier_unit: flow classifier over a bucketed hash table
// Insert, lookup and clear over NUM_BUCKETS buckets of WAYS entries.
// ----------------------------------------------------------------------------
// Each input word is one operation: lookup, insert or clear; each gives one
// result word (status, slot). The block works on one word at a time and
// stalls its input until the sequencer is back in idle; a finished result
// waits in the output register, so the next word can be taken meanwhile.
// When NUM_BUCKETS is a power of two the bucket index is the low hash bits;
// else it is the hash modulo NUM_BUCKETS by reciprocal multiplication
// on one shared 32x17 multiplier (two partial products for the quotient,
// then one for the remainder). Ways are compared by one shared
// comparator, one way at a time (entry RAM read, then compare).
// After reset the block sweeps the bucket fill RAM to zero before it
// takes its first word; configuration writes are taken at once.
// Entry validity is implied by the bucket fill count, so a clear only
// resets the fill counts.
// ----------------------------------------------------------------------------
module flow_hash_classifier_unit #(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_flow_id,
    input  logic [15:0] i_slot_in,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_slot_out,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // widths derived from the table shape
    localparam int BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW      = $clog2(WAYS + 1);
    localparam int ENTRIES = NUM_BUCKETS * WAYS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam bit POW2    = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    // reciprocal ceil(2^(32+BW) / NUM_BUCKETS), exact quotient for 32-bit hashes
    localparam logic [63:0] RECIP    = POW2 ? 64'd0 :
        ((64'd1 << (32 + BW)) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [16:0] RECIP_LO = {1'b0, RECIP[15:0]};
    localparam logic [16:0] RECIP_HI = RECIP[32:16];
    localparam logic [16:0] NB_M     = 17'(NUM_BUCKETS);

    localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);
    localparam logic [FW-1:0] WAYS_F   = FW'(WAYS);
    localparam logic [AW-1:0] WAYS_A   = AW'(WAYS);

    // configuration
    logic [31:0] r_dst_mask;
    logic [4:0]  r_dst_shift;
    logic        r_use_flow;

    // control
    fhc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            r_clr_reply, n_clr_reply;
    logic [BW-1:0]   r_clr, n_clr;
    logic [4:0]      r_cnt, n_cnt;

    // working registers
    logic [1:0]      r_op, n_op;
    logic [31:0]     r_src, n_src;
    logic [31:0]     r_dk, n_dk;
    logic [31:0]     r_flow, n_flow;
    logic [15:0]     r_slot_in, n_slot_in;
    logic [31:0]     r_hash, n_hash;
    logic [64:0]     r_prod, n_prod;
    logic [BW-1:0]   r_bucket, n_bucket;
    logic [FW-1:0]   r_fill, n_fill;
    logic [WW-1:0]   r_way, n_way;
    logic [1:0]      r_res_status, n_res_status;
    logic [15:0]     r_res_slot, n_res_slot;
    logic [1:0]      r_out_status, n_out_status;
    logic [15:0]     r_out_slot, n_out_slot;

    // RAM ports
    logic            w_fill_we;
    logic [BW-1:0]   w_fill_waddr;
    logic [FW-1:0]   w_fill_wdata;
    logic [FW-1:0]   w_fill_rd;
    logic            w_ent_we;
    logic [AW-1:0]   w_ent_waddr;
    logic [AW-1:0]   w_ent_raddr;
    fhc_pkg::t_entry w_ent_wdata;
    fhc_pkg::t_entry w_ent_rd;

    // helpers
    logic            w_accept;
    logic            w_out_free;
    logic [31:0]     w_dk;
    logic [31:0]     w_x0;
    logic [31:0]     w_x1;
    logic [31:0]     w_hash;
    logic [31:0]     w_mul_a;
    logic [16:0]     w_mul_b;
    logic [48:0]     w_mul_p;
    logic [31:0]     w_quot;
    logic            w_match;
    logic            w_full;

    function automatic logic [AW-1:0] f_addr(input logic [BW-1:0] bucket,
                                             input logic [WW-1:0] way);
        f_addr = AW'(bucket) * WAYS_A + AW'(way);
    endfunction

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    fhc_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_wdata),
        .i_raddr (r_bucket),
        .o_rdata (w_fill_rd)
    );

    fhc_ram #(
        .WIDTH (fhc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rd)
    );

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    assign w_accept   = i_in_valid && (r_state == fhc_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // lookup key: shifted and masked destination; insert stores it raw
    assign w_dk   = (i_operation == fhc_pkg::OP_LOOKUP) ?
                    ((i_dst_addr >> r_dst_shift) & r_dst_mask) : i_dst_addr;
    assign w_x0   = i_src_addr ^ w_dk ^ (r_use_flow ? i_flow_id : 32'd0);
    assign w_x1   = w_x0 ^ (w_x0 >> 16);
    assign w_hash = w_x1 ^ (w_x1 >> 8);

    // shared multiplier: hash * reciprocal in two halves, then quotient * count
    assign w_quot = 32'(r_prod >> (32 + BW));

    always_comb begin
        w_mul_a = r_hash;
        w_mul_b = RECIP_LO;
        case (r_cnt)
            5'd2: w_mul_b = RECIP_LO;
            5'd1: w_mul_b = RECIP_HI;
            default: begin
                w_mul_a = w_quot;
                w_mul_b = NB_M;
            end
        endcase
    end

    assign w_mul_p = 49'(w_mul_a) * 49'(w_mul_b);

    // shared way comparator
    assign w_match = (w_ent_rd.src == r_src) && (w_ent_rd.dst == r_dk) &&
                     (!r_use_flow || (w_ent_rd.flow == r_flow));

    assign w_full = (w_fill_rd >= WAYS_F);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fhc_pkg::ST_CLEAR: begin
                if (r_clr == LAST_BKT) begin
                    n_state = r_clr_reply ? fhc_pkg::ST_DONE : fhc_pkg::ST_IDLE;
                end
            end
            fhc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_operation) inside
                        fhc_pkg::OP_LOOKUP, fhc_pkg::OP_INSERT: begin
                            n_state = POW2 ? fhc_pkg::ST_FILL : fhc_pkg::ST_MOD;
                        end
                        fhc_pkg::OP_CLEAR: n_state = fhc_pkg::ST_CLEAR;
                        default:           n_state = fhc_pkg::ST_DONE;
                    endcase
                end
            end
            fhc_pkg::ST_MOD: begin
                if (r_cnt == 5'd0) begin
                    n_state = fhc_pkg::ST_FILL;
                end
            end
            fhc_pkg::ST_FILL: n_state = fhc_pkg::ST_FILLW;
            fhc_pkg::ST_FILLW: begin
                if (r_op == fhc_pkg::OP_LOOKUP && w_fill_rd != '0) begin
                    n_state = fhc_pkg::ST_PROBE;
                end else begin
                    n_state = fhc_pkg::ST_DONE;
                end
            end
            fhc_pkg::ST_PROBE: n_state = fhc_pkg::ST_CMP;
            fhc_pkg::ST_CMP: begin
                if (w_match) begin
                    n_state = fhc_pkg::ST_DONE;
                end else if (r_way == '0) begin
                    n_state = (r_fill > FW'(1)) ? fhc_pkg::ST_PROBE : fhc_pkg::ST_DONE;
                end else if (r_way > WW'(1)) begin
                    n_state = fhc_pkg::ST_PROBE;
                end else begin
                    n_state = fhc_pkg::ST_DONE;
                end
            end
            fhc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = fhc_pkg::ST_IDLE;
                end
            end
            default: n_state = fhc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs: stall and RAM controls
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall   = (r_state != fhc_pkg::ST_IDLE);
        w_fill_we    = 1'b0;
        w_fill_waddr = r_bucket;
        w_fill_wdata = w_fill_rd + FW'(1);
        w_ent_we     = 1'b0;
        w_ent_waddr  = f_addr(r_bucket, WW'(w_fill_rd));
        w_ent_raddr  = f_addr(r_bucket, r_way);
        w_ent_wdata  = '{src: r_src, dst: r_dk, flow: r_flow, slot: r_slot_in};
        unique case (r_state)
            fhc_pkg::ST_CLEAR: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = r_clr;
                w_fill_wdata = '0;
            end
            fhc_pkg::ST_FILLW: begin
                if (r_op == fhc_pkg::OP_INSERT && !w_full) begin
                    w_fill_we = 1'b1;
                    w_ent_we  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_clr_reply  = r_clr_reply;
        n_clr        = r_clr;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_src        = r_src;
        n_dk         = r_dk;
        n_flow       = r_flow;
        n_slot_in    = r_slot_in;
        n_hash       = r_hash;
        n_prod       = r_prod;
        n_bucket     = r_bucket;
        n_fill       = r_fill;
        n_way        = r_way;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;

        case (r_state)
            fhc_pkg::ST_CLEAR: begin
                n_clr = r_clr + BW'(1);
                if (r_clr == LAST_BKT) begin
                    n_clr_reply  = 1'b0;
                    n_res_status = fhc_pkg::STAT_OK;
                    n_res_slot   = '0;
                end
            end
            fhc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op         = i_operation;
                    n_src        = i_src_addr;
                    n_dk         = w_dk;
                    n_flow       = i_flow_id;
                    n_slot_in    = i_slot_in;
                    n_hash       = w_hash;
                    n_cnt        = 5'd2;
                    n_bucket     = (NUM_BUCKETS == 1) ? '0 : w_hash[BW-1:0];
                    n_clr        = '0;
                    n_clr_reply  = (i_operation == fhc_pkg::OP_CLEAR);
                    n_res_status = fhc_pkg::STAT_OK;
                    n_res_slot   = '0;
                end
            end
            fhc_pkg::ST_MOD: begin
                n_cnt = r_cnt - 5'd1;
                case (r_cnt)
                    5'd2: n_prod = 65'(w_mul_p);
                    5'd1: n_prod = r_prod + {w_mul_p, 16'b0};
                    // remainder = hash - quotient * bucket count
                    default: n_bucket = BW'(r_hash - w_mul_p[31:0]);
                endcase
            end
            fhc_pkg::ST_FILLW: begin
                n_fill = w_fill_rd;
                n_way  = '0;
                if (r_op == fhc_pkg::OP_INSERT) begin
                    n_res_status = w_full ? fhc_pkg::STAT_FULL : fhc_pkg::STAT_OK;
                end else if (w_fill_rd == '0) begin
                    n_res_status = fhc_pkg::STAT_MISS;
                end
            end
            fhc_pkg::ST_CMP: begin
                if (w_match) begin
                    n_res_status = fhc_pkg::STAT_OK;
                    n_res_slot   = w_ent_rd.slot;
                end else if (r_way == '0) begin
                    // oldest way missed: go on from the newest
                    n_way = WW'(r_fill - FW'(1));
                    if (!(r_fill > FW'(1))) begin
                        n_res_status = fhc_pkg::STAT_MISS;
                    end
                end else if (r_way > WW'(1)) begin
                    n_way = r_way - WW'(1);
                end else begin
                    n_res_status = fhc_pkg::STAT_MISS;
                end
            end
            fhc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fhc_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_reply <= 1'b0;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_dst_mask  <= 32'hFFFF_FFFF;
            r_dst_shift <= 5'd0;
            r_use_flow  <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_reply <= n_clr_reply;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fhc_pkg::CFG_DST_MASK:    r_dst_mask  <= i_cfg_data;
                    fhc_pkg::CFG_DST_SHIFT:   r_dst_shift <= i_cfg_data[4:0];
                    fhc_pkg::CFG_USE_FLOW_ID: r_use_flow  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_src        <= n_src;
        r_dk         <= n_dk;
        r_flow       <= n_flow;
        r_slot_in    <= n_slot_in;
        r_hash       <= n_hash;
        r_prod       <= n_prod;
        r_bucket     <= n_bucket;
        r_fill       <= n_fill;
        r_way        <= n_way;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot_out  = r_out_slot;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == fhc_pkg::ST_DONE)
        else $error("result loaded outside done state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fill_we && r_state == fhc_pkg::ST_FILLW) |-> w_fill_wdata <= WAYS_F)
        else $error("bucket fill count beyond way count");

    a_probe_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fhc_pkg::ST_CMP |-> FW'(r_way) < r_fill)
        else $error("probed way not filled");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fhc_pkg::ST_FILL |-> 32'(r_bucket) < NUM_BUCKETS)
        else $error("bucket index out of range");

    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != fhc_pkg::STAT_OK) |-> r_out_slot == '0)
        else $error("slot on a miss or full result");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for flow_hash_classifier_unit
// Feeds lookup, insert, clear and unused-code words through the valid/stall
// input channel. A behavioral copy of the bucketed table predicts every
// result word, and the monitor checks status and slot in order. Register
// settings change only while the unit is drained. The sender idles in
// bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS = 256;
    localparam int WAYS        = 4;
    localparam int NUM_ENTRIES = NUM_BUCKETS * WAYS;
    localparam int HOT_N       = 6;      // buckets aimed at per phase, so they fill up
    localparam int POOL_MAX    = 48;    // recent keys kept for lookups that should hit
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES = 40;    // settle time after the last result

    // code 3 has no name in the package: no state change, status ok
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] flow;
        logic [15:0] slot;
    } t_word;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] slot;
    } t_answer;

    // lookup key as the packet carries it; the destination is the raw one
    typedef struct {
        logic [31:0] src;
        logic [31:0] raw_dst;
        logic [31:0] flow;
    } t_flow_key;

    typedef enum {RX_FREE, RX_LIGHT, RX_BEAT, RX_HEAVY} t_rx_mode;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = fhc_pkg::OP_LOOKUP;
    logic [31:0] i_src_addr  = '0;
    logic [31:0] i_dst_addr  = '0;
    logic [31:0] i_flow_id   = '0;
    logic [15:0] i_slot_in   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_slot_out;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = fhc_pkg::CFG_DST_MASK;
    logic [31:0] i_cfg_data  = '0;

    flow_hash_classifier_unit #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_src_addr  (i_src_addr),
        .i_dst_addr  (i_dst_addr),
        .i_flow_id   (i_flow_id),
        .i_slot_in   (i_slot_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_slot_out  (o_slot_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Table model: register copies and bucket contents. Entry validity is
    // the bucket fill count, as in the unit; a clear only zeroes the counts.
    // ------------------------------------------------------------------------
    logic [31:0] cfg_mask     = '1;
    logic [4:0]  cfg_shift    = '0;
    logic        cfg_use_flow = 1'b1;

    logic [31:0] tbl_src  [NUM_ENTRIES];
    logic [31:0] tbl_dst  [NUM_ENTRIES];
    logic [31:0] tbl_flow [NUM_ENTRIES];
    logic [15:0] tbl_slot [NUM_ENTRIES];
    int unsigned tbl_fill [NUM_BUCKETS];

    // tallies for the closing summary
    int n_hits, n_misses, n_inserts, n_full, n_clears, n_unused, n_settings;

    // queues and handshake counters
    t_word     word_backlog[$];      // words waiting for the driver
    t_answer   expected_answers[$];  // predicted results, oldest first
    t_flow_key key_pool[$];          // keys inserted in the current phase
    int unsigned hot_buckets[HOT_N];

    int words_queued, words_offered, words_accepted, words_checked;
    int fail_count;
    bit hold_req;                    // raised once by the stimulus process

    // xor of the used fields, folded 32->16->8, then modulo the bucket count
    function automatic int unsigned flow_bucket(logic [31:0] s, logic [31:0] d,
                                                logic [31:0] f);
        logic [31:0] x;
        x = s ^ d;
        if (cfg_use_flow)
            x = x ^ f;
        x = x ^ (x >> 16);
        x = x ^ (x >> 8);
        return int'(x % NUM_BUCKETS);
    endfunction

    function automatic bit entry_matches(int unsigned idx, logic [31:0] s,
                                         logic [31:0] d, logic [31:0] f);
        if (tbl_src[idx] != s || tbl_dst[idx] != d)
            return 1'b0;
        if (cfg_use_flow && tbl_flow[idx] != f)
            return 1'b0;
        return 1'b1;
    endfunction

    // applies one accepted word to the table and returns its result word
    function automatic t_answer classify_word(t_word w);
        t_answer     a;
        logic [31:0] dk;
        int unsigned b;
        int unsigned base;
        int          fill;
        int          way;
        bit          hit;
        a.status = fhc_pkg::STAT_OK;
        a.slot   = '0;
        case (w.op)
            fhc_pkg::OP_LOOKUP: begin
                dk   = (w.dst >> cfg_shift) & cfg_mask;
                b    = flow_bucket(w.src, dk, w.flow);
                base = b * WAYS;
                fill = int'(tbl_fill[b]);
                hit  = 1'b0;
                // oldest way first, then newest down to way 1
                if (fill > 0 && entry_matches(base, w.src, dk, w.flow)) begin
                    hit    = 1'b1;
                    a.slot = tbl_slot[base];
                end
                for (way = fill - 1; way >= 1 && !hit; way--) begin
                    if (entry_matches(base + way, w.src, dk, w.flow)) begin
                        hit    = 1'b1;
                        a.slot = tbl_slot[base + way];
                    end
                end
                a.status = hit ? fhc_pkg::STAT_OK : fhc_pkg::STAT_MISS;
                if (hit)
                    n_hits++;
                else
                    n_misses++;
            end
            fhc_pkg::OP_INSERT: begin
                // insert hashes the destination as given
                b = flow_bucket(w.src, w.dst, w.flow);
                n_inserts++;
                if (tbl_fill[b] >= WAYS) begin
                    a.status = fhc_pkg::STAT_FULL;
                    n_full++;
                end else begin
                    base           = b * WAYS + tbl_fill[b];
                    tbl_src[base]  = w.src;
                    tbl_dst[base]  = w.dst;
                    tbl_flow[base] = w.flow;
                    tbl_slot[base] = w.slot;
                    tbl_fill[b]++;
                end
            end
            fhc_pkg::OP_CLEAR: begin
                foreach (tbl_fill[i])
                    tbl_fill[i] = 0;
                n_clears++;
            end
            default: begin
                n_unused++;
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("ERROR %0t ns: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver: words go out at the falling edge in bursts with gaps between.
    // A word stays on the port, unchanged, until the monitor counts it taken.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin : driver
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && words_accepted != words_offered) begin
            // stalled: hold valid and payload
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
            w = word_backlog.pop_front();
            i_operation <= w.op;
            i_src_addr  <= w.src;
            i_dst_addr  <= w.dst;
            i_flow_id   <= w.flow;
            i_slot_in   <= w.slot;
            i_in_valid  <= 1'b1;
            words_offered++;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                // now and then a long gap-free stretch
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 7);
                gap_left   = $urandom_range(1, 6);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern switches mode at random. A single long
    // hold-off, counted here, lets the unit back up into its input.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rx_cycle  = 0;

    always @(negedge i_clk) begin : receiver
        rx_cycle++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 40);
                RX_BEAT:  i_out_stall <= (rx_cycle % 3 == 0);
                default:  i_out_stall <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, check a delivered result against the
    // oldest prediction, then predict for a word the unit takes. A result
    // never belongs to the word taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_answer want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: status %0d slot %h",
                                              o_status, o_slot_out));
                end else begin
                    want = expected_answers.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("word %0d: status %0d, expected %0d",
                                                  words_checked, o_status, want.status));
                    if (o_slot_out !== want.slot)
                        report_mismatch($sformatf("word %0d: slot %h, expected %h",
                                                  words_checked, o_slot_out, want.slot));
                    words_checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_answers.push_back(classify_word('{i_operation, i_src_addr,
                                                           i_dst_addr, i_flow_id, i_slot_in}));
                words_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input t_word w);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    // waits until every queued word has its result back
    task automatic wait_drained();
        while (words_checked != words_queued)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fhc_pkg::CFG_DST_MASK:    cfg_mask     = data;
            fhc_pkg::CFG_DST_SHIFT:   cfg_shift    = data[4:0];
            fhc_pkg::CFG_USE_FLOW_ID: cfg_use_flow = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [31:0] mask, input logic [4:0] shift,
                                 input logic use_flow);
        write_reg(fhc_pkg::CFG_DST_MASK, mask);
        write_reg(fhc_pkg::CFG_DST_SHIFT, {27'b0, shift});
        write_reg(fhc_pkg::CFG_USE_FLOW_ID, {31'b0, use_flow});
        n_settings++;
    endtask

    // bucket index only depends on the xor of the hash bytes, so flipping
    // source bits 7:0 moves a key to any bucket (bucket count a power of two
    // up to 256)
    function automatic logic [31:0] aim_src(logic [31:0] s, logic [31:0] d,
                                            logic [31:0] f, int unsigned target);
        logic [7:0] delta;
        delta = 8'(flow_bucket(s, d, f) ^ target);
        return {s[31:8], s[7:0] ^ delta};
    endfunction

    function automatic logic [31:0] rand_field32();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] lookup_dst(logic [31:0] raw);
        return (raw >> cfg_shift) & cfg_mask;
    endfunction

    // short directed run under reset register values (destination unchanged)
    task automatic queue_directed();
        logic [31:0] ks [5];
        logic [31:0] kd [5];
        logic [31:0] kf [5];
        logic [31:0] xs, xd, xf, ds, dd, df;
        int          i;
        queue_word('{fhc_pkg::OP_LOOKUP, '0, '0, '0, '0});     // empty table
        queue_word('{fhc_pkg::OP_INSERT, '1, '1, '1, '1});
        queue_word('{fhc_pkg::OP_LOOKUP, '1, '1, '1, '0});
        queue_word('{fhc_pkg::OP_INSERT, '0, '0, '0, '0});     // same bucket as all ones
        queue_word('{fhc_pkg::OP_LOOKUP, '0, '0, '0, '1});
        queue_word('{OP_UNUSED, '1, '1, '1, '1});
        // five keys aimed at one bucket: the fifth finds it full
        for (i = 0; i < 5; i++) begin
            kd[i] = $urandom;
            kf[i] = $urandom;
            ks[i] = aim_src($urandom, kd[i], kf[i], 'h5A);
            queue_word('{fhc_pkg::OP_INSERT, ks[i], kd[i], kf[i], 16'(i + 1)});
        end
        queue_word('{fhc_pkg::OP_LOOKUP, ks[0], kd[0], kf[0], '0});
        queue_word('{fhc_pkg::OP_LOOKUP, ks[3], kd[3], kf[3], '0});
        queue_word('{fhc_pkg::OP_LOOKUP, ks[4], kd[4], kf[4], '0});      // was dropped
        queue_word('{fhc_pkg::OP_LOOKUP, ks[1], kd[1], kf[1] ^ 32'd1, '0});
        // duplicate key behind an unrelated oldest entry: newest copy answers
        xd = $urandom;
        xf = $urandom;
        xs = aim_src($urandom, xd, xf, 'h33);
        dd = $urandom;
        df = $urandom;
        ds = aim_src($urandom, dd, df, 'h33);
        queue_word('{fhc_pkg::OP_INSERT, xs, xd, xf, 16'd20});
        queue_word('{fhc_pkg::OP_INSERT, ds, dd, df, 16'd21});
        queue_word('{fhc_pkg::OP_INSERT, ds, dd, df, 16'd22});
        queue_word('{fhc_pkg::OP_LOOKUP, ds, dd, df, '0});
        // clear, then the full bucket takes inserts again
        queue_word('{fhc_pkg::OP_CLEAR, '1, '1, '1, '1});
        queue_word('{fhc_pkg::OP_LOOKUP, '1, '1, '1, '0});
        queue_word('{fhc_pkg::OP_INSERT, ks[4], kd[4], kf[4], 16'd5});
        queue_word('{fhc_pkg::OP_LOOKUP, ks[4], kd[4], kf[4], '0});
    endtask

    // random words, mostly inserts into a few hot buckets and lookups of keys
    // already inserted, with noise: stray lookups, bit-flipped keys, unused
    // codes and an occasional clear
    task automatic queue_random(input int count);
        t_flow_key k;
        t_word     w;
        int        kind;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            w    = '{fhc_pkg::OP_LOOKUP, $urandom, $urandom, $urandom, 16'($urandom)};
            if (kind < 35 || (kind < 75 && key_pool.size() == 0)) begin
                k.src     = rand_field32();
                k.raw_dst = rand_field32();
                k.flow    = rand_field32();
                if ($urandom_range(0, 9) < 7)
                    k.src = aim_src(k.src, lookup_dst(k.raw_dst), k.flow,
                                    hot_buckets[$urandom_range(0, HOT_N - 1)]);
                // stored as the lookup will see it after shift and mask
                w = '{fhc_pkg::OP_INSERT, k.src, lookup_dst(k.raw_dst), k.flow,
                      16'($urandom)};
                key_pool.push_back(k);
                if (key_pool.size() > POOL_MAX)
                    void'(key_pool.pop_front());
            end else if (kind < 75) begin
                k      = key_pool[$urandom_range(0, key_pool.size() - 1)];
                w.src  = k.src;
                w.flow = k.flow;
                // destination bits that shift and mask drop are free to vary
                w.dst  = k.raw_dst ^ ($urandom & ~(cfg_mask << cfg_shift));
                case ($urandom_range(0, 9))
                    0:       w.flow = w.flow ^ (32'd1 << $urandom_range(0, 31));
                    1:       w.src  = w.src ^ (32'd1 << $urandom_range(0, 31));
                    default: ;
                endcase
            end else if (kind < 86) begin
                w.src  = rand_field32();
                w.dst  = rand_field32();
                w.flow = rand_field32();
            end else if (kind < 93 && key_pool.size() > 0) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                w = '{fhc_pkg::OP_INSERT, k.src, lookup_dst(k.raw_dst), k.flow,
                      16'($urandom)};
            end else if (kind < 97) begin
                w.op = OP_UNUSED;
            end else begin
                w.op = fhc_pkg::OP_CLEAR;
                key_pool.delete();
            end
            queue_word(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] set_mask  [7];
        logic [4:0]  set_shift [7];
        logic        set_flow  [7];
        int          p;

        foreach (tbl_fill[i])
            tbl_fill[i] = 0;

        // extremes of mask and shift, both flow modes, back to reset values
        set_mask  = '{'1, $urandom, '0, '1, '0, $urandom, '1};
        set_shift = '{5'd0, 5'($urandom), 5'd31, 5'd31, 5'd0, 5'($urandom), 5'd0};
        set_flow  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'($urandom), 1'b1};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        for (p = 0; p < 7; p++) begin
            apply_setting(set_mask[p], set_shift[p], set_flow[p]);
            foreach (hot_buckets[j])
                hot_buckets[j] = $urandom_range(0, NUM_BUCKETS - 1);
            key_pool.delete();
            queue_random(40);
            // receiver goes quiet while the sender keeps offering words
            if (p == 1)
                hold_req = 1'b1;
            // sender pauses here until every result is back
            wait_drained();
            queue_random(40);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_answers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));

        $display("Ran %0d words over %0d register settings: %0d inserts (%0d to full buckets),",
                 words_checked, n_settings, n_inserts, n_full);
        $display("  %0d lookup hits, %0d misses, %0d clears, %0d unused codes; %0d errors",
                 n_hits, n_misses, n_clears, n_unused, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("Timeout with %0d of %0d words checked", words_checked, words_queued);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
